// ===== src/bni_pkg.sv =====
// bni_pkg: shared types and constants for the batch normalisation block
// used by bni_engine, bni_param_mem and batch_norm_inference_top
package bni_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CHANNEL_TOTAL = 2'd0;
  localparam logic [1:0] REG_PLANE_SIZE    = 2'd1;
  localparam logic [1:0] REG_EPSILON_Q     = 2'd2;

  localparam int CFG_DATA_W = 25;

  // item operations
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // plane size is clamped to this many elements
  localparam logic [24:0] PLANE_LIMIT = 25'h100_0000;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // engine operations
  localparam logic ENG_ROOTDIV = 1'b0;
  localparam logic ENG_MUL     = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } eng_req_t;

  typedef struct packed {
    logic done;
    logic root_zero;
  } eng_stat_t;

  // one channel's stored parameters
  typedef struct packed {
    logic [31:0] coef;
    logic [31:0] mean;
    logic [31:0] bias;
    logic        clip;
  } entry_t;

endpackage

// ===== src/bni_engine.sv =====
// bni_engine: iterative root, divide and multiply sharing one add/subtract unit
// one result bit per cycle; depends on bni_pkg
module bni_engine #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bni_pkg::eng_req_t       req,
  input  logic [32:0]             sum,
  input  logic [31:0]             mag,
  input  logic [31:0]             md,
  input  logic [31:0]             mc,
  output bni_pkg::eng_stat_t      stat,
  output logic [32+FRAC_BITS-1:0] quotient,
  output logic [63:0]             product
);

  localparam int RAD_W = 33 + FRAC_BITS;
  localparam int WW    = RAD_W + (RAD_W % 2);
  localparam int RW    = WW / 2;
  localparam int DW    = 32 + FRAC_BITS;
  localparam int SW    = (RW + 3 > 33) ? RW + 3 : 33;
  localparam int CNT_W = $clog2(WW + 1);

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_SQRT  = 3'd1;
  localparam logic [2:0] E_DIVLD = 3'd2;
  localparam logic [2:0] E_DIV   = 3'd3;
  localparam logic [2:0] E_MUL   = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [SW-1:0]    rem;
  logic [WW-1:0]    work;
  logic [RW-1:0]    root;
  logic             done;
  logic             root_zero;

  logic [SW-1:0]    sq_trial;
  logic [SW-1:0]    dv_trial;
  logic [SW-1:0]    add_a;
  logic [SW-1:0]    add_b;
  logic             add_sub;
  logic [SW:0]      add_res;
  logic             carry;

  assign sq_trial = {rem[SW-3:0], work[WW-1:WW-2]};
  assign dv_trial = {rem[SW-2:0], work[WW-1]};

  always_comb begin
    case (state)
      E_SQRT: begin
        add_a   = sq_trial;
        add_b   = SW'({root, 2'b01});
        add_sub = 1'b1;
      end
      E_DIV: begin
        add_a   = dv_trial;
        add_b   = SW'(root);
        add_sub = 1'b1;
      end
      default: begin
        add_a   = rem;
        add_b   = work[0] ? SW'(mc) : '0;
        add_sub = 1'b0;
      end
    endcase
  end

  // the shared unit: carry out of a subtract means a >= b
  assign add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{SW{1'b0}}, add_sub};
  assign carry   = add_res[SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        E_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            rem  <= '0;
            root <= '0;
            if (req.op == bni_pkg::ENG_ROOTDIV) begin
              work  <= WW'({sum, {FRAC_BITS{1'b0}}});
              count <= CNT_W'(RW);
              state <= E_SQRT;
            end else begin
              work  <= WW'(md);
              count <= CNT_W'(32);
              state <= E_MUL;
            end
          end
        end
        E_SQRT: begin
          rem   <= carry ? add_res[SW-1:0] : sq_trial;
          root  <= {root[RW-2:0], carry};
          work  <= work << 2;
          count <= count - 1'b1;
          if (count == CNT_W'(1)) state <= E_DIVLD;
        end
        E_DIVLD: begin
          root_zero <= (root == '0);
          if (root == '0) begin
            done  <= 1'b1;
            state <= E_IDLE;
          end else begin
            // dividend is mag shifted up by the fraction bits, left aligned
            rem   <= '0;
            work  <= {mag, {(WW-32){1'b0}}};
            count <= CNT_W'(DW);
            state <= E_DIV;
          end
        end
        E_DIV: begin
          rem   <= carry ? add_res[SW-1:0] : dv_trial;
          work  <= {work[WW-2:0], carry};
          count <= count - 1'b1;
          if (count == CNT_W'(1)) begin
            done  <= 1'b1;
            state <= E_IDLE;
          end
        end
        E_MUL: begin
          // shift-add, product builds up in {rem, work[31:0]}
          rem   <= add_res[SW:1];
          work  <= {work[WW-1:32], add_res[0], work[31:1]};
          count <= count - 1'b1;
          if (count == CNT_W'(1)) begin
            done  <= 1'b1;
            state <= E_IDLE;
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign stat.done      = done;
  assign stat.root_zero = root_zero;
  assign quotient       = work[DW-1:0];
  assign product        = {rem[31:0], work[31:0]};

endmodule

// ===== src/bni_param_mem.sv =====
// bni_param_mem: per-channel coefficient, mean, bias and clip store
// one write and one registered read per cycle; depends on bni_pkg
module bni_param_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bni_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr,
  output bni_pkg::entry_t  rdata
);

  bni_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/batch_norm_inference_top.sv =====
// batch_norm_inference_top: inference batch normalisation, fixed point
// depends on bni_pkg, bni_engine and bni_param_mem
//
// Input channel (in_valid / in_stall): operation 0 loads one channel's scale,
// bias, mean and variance; operation 1 normalises one sample. in_stall is high
// whenever an item is in progress, so one item is handled at a time.
// Output channel (out_valid / out_stall): one beat per sample with the
// saturated result, a clip flag and the sample's channel. Loads give no beat.
// A load runs a bit-serial square root and divide in the shared engine and
// holds in_stall until its entry is written to the parameter store; a load
// naming a channel at or above MAX_CHANNELS is dropped at once.
// A sample passes through S_READ, S_ABS, S_MUL and S_SUM, using the 32-step
// shift-add multiply in the same engine; the next item can follow once its beat is registered.
// The output register holds a finished beat while out_stall is high; the next
// item is still taken, and its result waits in the last step until the
// register frees up.
// Reset holds in_stall high, clears the channel and plane counters and sets
// channel_total, plane_size and epsilon_q to 1; the parameter store is not
// cleared and must be loaded before its channel is sampled.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and are meant for idle periods only.
module batch_norm_inference_top #(
  parameter int MAX_CHANNELS = 256,
  parameter int FRAC_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [bni_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [7:0]                     channel_sel,
  input  logic signed [31:0]             scale_in,
  input  logic signed [31:0]             bias_in,
  input  logic signed [31:0]             mean_in,
  input  logic [31:0]                    variance_in,
  input  logic signed [31:0]             sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             sample_out,
  output logic                           saturated,
  output logic [7:0]                     channel_out
);

  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CTW = ($clog2(MAX_CHANNELS + 1) > 9) ? $clog2(MAX_CHANNELS + 1) : 9;
  localparam int DW  = 32 + FRAC_BITS;
  localparam int PW  = 64 - FRAC_BITS;
  localparam int VW  = PW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_ABS  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;

  // configuration
  logic [8:0]  channel_total;
  logic [24:0] plane_size;
  logic [15:0] epsilon_q;

  // control
  logic [2:0]     state;
  logic [CHW-1:0] current_channel;
  logic [23:0]    plane_position;
  logic           eng_start;
  logic           eng_op;

  // load payload
  logic [CHW-1:0] ld_ch;
  logic [31:0]    ld_mean;
  logic [31:0]    ld_bias;
  logic           ld_neg;
  logic [31:0]    ld_mag;
  logic [32:0]    ld_sum;

  // sample payload
  logic [31:0]    smp_val;
  logic [CHW-1:0] smp_ch;
  logic [32:0]    diff;
  logic [31:0]    cf;
  logic [31:0]    bs;
  logic           cclip;
  logic [31:0]    md;
  logic [31:0]    mc;
  logic           prod_neg;
  logic [PW-1:0]  rnd;

  logic in_accept;
  logic out_free;

  bni_pkg::eng_req_t  eng_req;
  bni_pkg::eng_stat_t eng_stat;
  logic [DW-1:0]      eng_quotient;
  logic [63:0]        eng_product;

  bni_pkg::entry_t mem_wdata;
  bni_pkg::entry_t mem_rdata;
  logic            mem_we;

  logic           ld_in_range;
  logic           q_over;
  logic [31:0]    q_lim;
  logic [31:0]    q_clamped;
  logic [63:0]    prod_rounded;
  logic [VW-1:0]  bias_ext;
  logic [VW-1:0]  rnd_ext;
  logic [VW-1:0]  val;
  logic           val_hi;
  logic           val_lo;
  logic [31:0]    val_sat;
  logic [24:0]    eff_plane;
  logic [CTW-1:0] eff_channels;
  logic [24:0]    pos_inc;
  logic [CTW-1:0] ch_inc;

  assign in_stall  = (state != S_IDLE) || rst;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign ld_in_range = CTW'(channel_sel) < CTW'(MAX_CHANNELS);

  assign eng_req.start = eng_start;
  assign eng_req.op    = eng_op;

  bni_engine #(
    .FRAC_BITS(FRAC_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .req      (eng_req),
    .sum      (ld_sum),
    .mag      (ld_mag),
    .md       (md),
    .mc       (mc),
    .stat     (eng_stat),
    .quotient (eng_quotient),
    .product  (eng_product)
  );

  bni_param_mem #(
    .DEPTH(MAX_CHANNELS),
    .AW   (CHW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ld_ch),
    .wdata (mem_wdata),
    .raddr (current_channel),
    .rdata (mem_rdata)
  );

  // coefficient: clamp the quotient, then apply the scale sign
  assign q_lim     = ld_neg ? bni_pkg::S32_MIN : bni_pkg::S32_MAX;
  assign q_over    = (|eng_quotient[DW-1:32]) || (eng_quotient[31:0] > q_lim);
  assign q_clamped = q_over ? q_lim : eng_quotient[31:0];

  always_comb begin
    mem_wdata.mean = ld_mean;
    mem_wdata.bias = ld_bias;
    if (eng_stat.root_zero) begin
      mem_wdata.clip = 1'b1;
      if (ld_neg) begin
        mem_wdata.coef = bni_pkg::S32_MIN;
      end else if (ld_mag != '0) begin
        mem_wdata.coef = bni_pkg::S32_MAX;
      end else begin
        mem_wdata.coef = '0;
      end
    end else begin
      mem_wdata.clip = q_over;
      mem_wdata.coef = ld_neg ? (~q_clamped + 32'd1) : q_clamped;
    end
  end

  assign mem_we = (state == S_LOAD) && eng_stat.done;

  // round to nearest, ties away from zero, on the magnitude
  assign prod_rounded = eng_product + (64'd1 << (FRAC_BITS - 1));

  assign bias_ext = {{(VW-32){bs[31]}}, bs};
  assign rnd_ext  = {2'b00, rnd};
  assign val      = prod_neg ? (bias_ext - rnd_ext) : (bias_ext + rnd_ext);
  assign val_hi   = !val[VW-1] && (|val[VW-2:31]);
  assign val_lo   = val[VW-1] && !(&val[VW-2:31]);

  always_comb begin
    if (val_hi) begin
      val_sat = bni_pkg::S32_MAX;
    end else if (val_lo) begin
      val_sat = bni_pkg::S32_MIN;
    end else begin
      val_sat = val[31:0];
    end
  end

  // effective counter bounds
  always_comb begin
    if (plane_size == '0) begin
      eff_plane = 25'd1;
    end else if (plane_size > bni_pkg::PLANE_LIMIT) begin
      eff_plane = bni_pkg::PLANE_LIMIT;
    end else begin
      eff_plane = plane_size;
    end
    if (channel_total == '0) begin
      eff_channels = CTW'(1);
    end else if (CTW'(channel_total) > CTW'(MAX_CHANNELS)) begin
      eff_channels = CTW'(MAX_CHANNELS);
    end else begin
      eff_channels = CTW'(channel_total);
    end
  end

  assign pos_inc = {1'b0, plane_position} + 25'd1;
  assign ch_inc  = CTW'(current_channel) + CTW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_total <= 9'd1;
      plane_size    <= 25'd1;
      epsilon_q     <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        bni_pkg::REG_CHANNEL_TOTAL: channel_total <= cfg_data[8:0];
        bni_pkg::REG_PLANE_SIZE:    plane_size    <= cfg_data[24:0];
        bni_pkg::REG_EPSILON_Q:     epsilon_q     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_channel <= '0;
      plane_position  <= '0;
      eng_start       <= 1'b0;
      eng_op          <= bni_pkg::ENG_ROOTDIV;
      out_valid       <= 1'b0;
    end else begin
      eng_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (operation == bni_pkg::OP_LOAD) begin
              if (ld_in_range) begin
                ld_ch     <= CHW'(channel_sel);
                ld_mean   <= mean_in;
                ld_bias   <= bias_in;
                ld_neg    <= scale_in[31];
                ld_mag    <= scale_in[31] ? (~scale_in + 32'd1) : scale_in;
                ld_sum    <= {1'b0, variance_in} + {17'd0, epsilon_q};
                eng_start <= 1'b1;
                eng_op    <= bni_pkg::ENG_ROOTDIV;
                state     <= S_LOAD;
              end
            end else begin
              smp_val <= sample_in;
              smp_ch  <= current_channel;
              state   <= S_READ;
            end
          end
        end
        S_LOAD: begin
          if (eng_stat.done) state <= S_IDLE;
        end
        S_READ: begin
          diff  <= {smp_val[31], smp_val} - {mem_rdata.mean[31], mem_rdata.mean};
          cf    <= mem_rdata.coef;
          bs    <= mem_rdata.bias;
          cclip <= mem_rdata.clip;
          state <= S_ABS;
        end
        S_ABS: begin
          md        <= diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
          mc        <= cf[31] ? (~cf + 32'd1) : cf;
          prod_neg  <= diff[32] ^ cf[31];
          eng_start <= 1'b1;
          eng_op    <= bni_pkg::ENG_MUL;
          state     <= S_MUL;
        end
        S_MUL: begin
          if (eng_stat.done) begin
            rnd   <= prod_rounded[63:FRAC_BITS];
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // wait here until the output register can take the beat
          if (out_free) begin
            sample_out  <= val_sat;
            saturated   <= cclip || val_hi || val_lo;
            channel_out <= 8'(smp_ch);
            out_valid   <= 1'b1;
            if (pos_inc >= eff_plane) begin
              plane_position <= '0;
              if (ch_inc >= eff_channels) begin
                current_channel <= '0;
              end else begin
                current_channel <= ch_inc[CHW-1:0];
              end
            end else begin
              plane_position <= pos_inc[23:0];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
